@@ hw/rtl/poll_backoff_scheduler_top_assert.svh @@
// Assertion macros shared by the poll scheduler RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef POLL_BACKOFF_SCHEDULER_TOP_ASSERT_SVH
`define POLL_BACKOFF_SCHEDULER_TOP_ASSERT_SVH

// Condition in the same cycle.
`define PBS_ASSERT_SAME(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Condition, then the property in the next cycle.
`define PBS_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ hw/rtl/pbs_pkg.sv @@
// Shared types, codes and helpers of the poll backoff scheduler.
// No dependencies; imported by every module of the block.
package pbs_pkg;

   localparam int TIME_W  = 32;
   localparam int OP_W    = 3;
   localparam int IDX_W   = 3;
   localparam int REQ_D_W = 40;
   localparam int RSP_D_W = 40;

   localparam logic [OP_W-1:0] OP_QUERY     = 3'd0;
   localparam logic [OP_W-1:0] OP_ADVERT    = 3'd1;
   localparam logic [OP_W-1:0] OP_START     = 3'd2;
   localparam logic [OP_W-1:0] OP_FINISH    = 3'd3;
   localparam logic [OP_W-1:0] OP_REQ_POLL  = 3'd4;
   localparam logic [OP_W-1:0] OP_REQ_RETRY = 3'd5;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd6;

   localparam logic [IDX_W-1:0] REG_TAIL_SETTLE = 3'd0;
   localparam logic [IDX_W-1:0] REG_FRESH_WIN   = 3'd1;
   localparam logic [IDX_W-1:0] REG_NORMAL_INT  = 3'd2;
   localparam logic [IDX_W-1:0] REG_FIRST_RETRY = 3'd3;
   localparam logic [IDX_W-1:0] REG_MAX_RETRY   = 3'd4;
   localparam logic [IDX_W-1:0] REG_RETRY_GAP   = 3'd5;
   localparam logic [IDX_W-1:0] REG_MIN_GAP     = 3'd6;

   typedef struct packed {
      logic [TIME_W-1:0] tail_settle_time;
      logic [TIME_W-1:0] freshness_window;
      logic [TIME_W-1:0] normal_interval;
      logic [TIME_W-1:0] first_retry_delay;
      logic [TIME_W-1:0] max_retry_delay;
      logic [TIME_W-1:0] retry_gap;
      logic [TIME_W-1:0] min_start_gap;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [TIME_W-1:0] now_time;
      logic              demand_flag;
      logic              poll_ok;
      logic              link_busy;
      logic              cleanup_busy;
   } event_type;

   typedef struct packed {
      logic              poll_now;
      logic              advert_fresh;
      logic [TIME_W-1:0] current_backoff;
   } result_type;

   // Wrapping elapsed-time test: at least dur ms since the mark.
   function automatic logic time_passed(input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] since,
                                        input logic [TIME_W-1:0] dur);
      logic [TIME_W-1:0] diff;
      diff = now - since;
      return diff >= dur;
   endfunction

endpackage

@@ hw/rtl/pbs_csr.sv @@
// Configuration register file of the poll backoff scheduler.
// Depends on pbs_pkg for the register indexes and the cfg_type bundle.
module pbs_csr
   import pbs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [TIME_W-1:0]   csr_data,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TAIL_SETTLE: cfg_in.tail_settle_time  = csr_data;
            REG_FRESH_WIN:   cfg_in.freshness_window  = csr_data;
            REG_NORMAL_INT:  cfg_in.normal_interval   = csr_data;
            REG_FIRST_RETRY: cfg_in.first_retry_delay = csr_data;
            REG_MAX_RETRY:   cfg_in.max_retry_delay   = csr_data;
            REG_RETRY_GAP:   cfg_in.retry_gap         = csr_data;
            REG_MIN_GAP:     cfg_in.min_start_gap     = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/pbs_state.sv @@
// Scheduler state, its update for one event, and the poll decision.
// Depends on pbs_pkg and the assertion macro header.
`include "poll_backoff_scheduler_top_assert.svh"
module pbs_state
   import pbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  event_type  evt,
   input  cfg_type    cfg,
   output result_type result
);

   logic [TIME_W-1:0] finish_time_ff, finish_time_in;
   logic [TIME_W-1:0] start_time_ff, start_time_in;
   logic [TIME_W-1:0] advert_time_ff, advert_time_in;
   logic [TIME_W-1:0] retry_ready_ff, retry_ready_in;
   logic [TIME_W-1:0] backoff_ff, backoff_in;
   logic [TIME_W-1:0] wait_delay_ff, wait_delay_in;
   logic              finished_once_ff, finished_once_in;
   logic              started_once_ff, started_once_in;
   logic              advert_seen_ff, advert_seen_in;
   logic              invite_ff, invite_in;
   logic              poll_wanted_ff, poll_wanted_in;
   logic              retry_wanted_ff, retry_wanted_in;

   logic              in_tail;
   logic              silent;
   logic              fresh;
   logic              gap_open;
   logic              poll_now;
   logic [TIME_W-1:0] retry_diff;
   logic [TIME_W-1:0] max_half;

   assign max_half = cfg.max_retry_delay >> 1;
   assign in_tail  = finished_once_ff
                     && !time_passed(evt.now_time, finish_time_ff, cfg.tail_settle_time);
   assign silent   = !advert_seen_ff
                     || time_passed(evt.now_time, advert_time_ff, cfg.freshness_window);

   always_comb begin
      finish_time_in   = finish_time_ff;
      start_time_in    = start_time_ff;
      advert_time_in   = advert_time_ff;
      retry_ready_in   = retry_ready_ff;
      backoff_in       = backoff_ff;
      wait_delay_in    = wait_delay_ff;
      finished_once_in = finished_once_ff;
      started_once_in  = started_once_ff;
      advert_seen_in   = advert_seen_ff;
      invite_in        = invite_ff;
      poll_wanted_in   = poll_wanted_ff;
      retry_wanted_in  = retry_wanted_ff;
      case (evt.opcode)
         OP_ADVERT: begin
            if (!in_tail) begin
               advert_time_in = evt.now_time;
               advert_seen_in = 1'b1;
               if (evt.demand_flag || silent) begin
                  invite_in = 1'b1;
               end
            end
         end
         OP_START: begin
            start_time_in   = evt.now_time;
            started_once_in = 1'b1;
            poll_wanted_in  = 1'b0;
            retry_wanted_in = 1'b0;
            invite_in       = 1'b0;
         end
         OP_FINISH: begin
            finish_time_in   = evt.now_time;
            finished_once_in = 1'b1;
            invite_in        = 1'b0;
            if (evt.poll_ok) begin
               backoff_in    = '0;
               wait_delay_in = cfg.normal_interval;
            end else begin
               if (backoff_ff == '0) begin
                  backoff_in = (cfg.first_retry_delay < cfg.max_retry_delay)
                               ? cfg.first_retry_delay : cfg.max_retry_delay;
               end else if (backoff_ff >= cfg.max_retry_delay || backoff_ff > max_half) begin
                  backoff_in = cfg.max_retry_delay;
               end else begin
                  backoff_in = {backoff_ff[TIME_W-2:0], 1'b0};
               end
               wait_delay_in = backoff_in;
            end
         end
         OP_REQ_POLL: begin
            poll_wanted_in = 1'b1;
         end
         OP_REQ_RETRY: begin
            retry_wanted_in = 1'b1;
            retry_ready_in  = evt.now_time + cfg.retry_gap;
         end
         OP_CLEAR: begin
            poll_wanted_in  = 1'b0;
            retry_wanted_in = 1'b0;
         end
         default: begin
            // Queries and the spare code leave the state alone.
            poll_wanted_in = poll_wanted_ff;
         end
      endcase
   end

   // The decision looks at the state as it stands after this event.
   assign retry_diff = evt.now_time - retry_ready_in;
   assign fresh      = advert_seen_in
                       && !time_passed(evt.now_time, advert_time_in, cfg.freshness_window);
   assign gap_open   = !started_once_in
                       || time_passed(evt.now_time, start_time_in, cfg.min_start_gap);

   always_comb begin
      if (evt.link_busy || evt.cleanup_busy || !fresh) begin
         poll_now = 1'b0;
      end else if (retry_wanted_in) begin
         poll_now = !retry_diff[TIME_W-1];
      end else if (!gap_open) begin
         poll_now = 1'b0;
      end else if (poll_wanted_in || invite_in || !finished_once_in) begin
         poll_now = 1'b1;
      end else begin
         poll_now = time_passed(evt.now_time, finish_time_in, wait_delay_in);
      end
   end

   assign result.poll_now        = poll_now;
   assign result.advert_fresh    = fresh;
   assign result.current_backoff = backoff_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         finish_time_ff   <= '0;
         start_time_ff    <= '0;
         advert_time_ff   <= '0;
         retry_ready_ff   <= '0;
         backoff_ff       <= '0;
         wait_delay_ff    <= '0;
         finished_once_ff <= 1'b0;
         started_once_ff  <= 1'b0;
         advert_seen_ff   <= 1'b0;
         invite_ff        <= 1'b0;
         poll_wanted_ff   <= 1'b0;
         retry_wanted_ff  <= 1'b0;
      end else if (step) begin
         finish_time_ff   <= finish_time_in;
         start_time_ff    <= start_time_in;
         advert_time_ff   <= advert_time_in;
         retry_ready_ff   <= retry_ready_in;
         backoff_ff       <= backoff_in;
         wait_delay_ff    <= wait_delay_in;
         finished_once_ff <= finished_once_in;
         started_once_ff  <= started_once_in;
         advert_seen_ff   <= advert_seen_in;
         invite_ff        <= invite_in;
         poll_wanted_ff   <= poll_wanted_in;
         retry_wanted_ff  <= retry_wanted_in;
      end
   end

   `PBS_ASSERT_NEXT(a_backoff_capped, step && evt.opcode == OP_FINISH && !evt.poll_ok, backoff_ff <= cfg.max_retry_delay, "backoff above its ceiling after a failed poll")
   `PBS_ASSERT_NEXT(a_success_clears, step && evt.opcode == OP_FINISH && evt.poll_ok, backoff_ff == '0 && wait_delay_ff == $past(cfg.normal_interval), "successful poll did not clear the backoff")
   `PBS_ASSERT_NEXT(a_start_clears, step && evt.opcode == OP_START, !poll_wanted_ff && !retry_wanted_ff && !invite_ff && started_once_ff, "poll start left a request pending")

endmodule

@@ hw/rtl/poll_backoff_scheduler_top.sv @@
// Top level of the poll backoff scheduler: request and response registers
// around the state update. Depends on pbs_pkg, pbs_csr, pbs_state and the
// assertion macro header.
//
// Usage:
//  - Events arrive on the req_ channel: req_tuser carries the opcode and
//    req_tdata the time and the event flags. Each accepted request yields
//    exactly one response on the rsp_ channel, in order.
//  - A request is registered on acceptance and applied to the scheduler state
//    once the response register is free or being read, when its result is
//    written into the response register.
//  - Throughput is one request per cycle while rsp_tready is high; the limit is
//    the single state update each event makes before the next reads the state.
//  - When the receiver holds rsp_tready low, the response register keeps its
//    result and one more request is held in the input register; after that
//    req_tready drops until the response is taken.
//  - Registers must be written through csr_ only while no request is in flight;
//    the block does not enforce it, is always ready, ignores indexes past the list.
//  - Synchronous reset clears the scheduler state, every register and both
//    channel stages; the block accepts requests in the first cycle after it.
`include "poll_backoff_scheduler_top_assert.svh"
module poll_backoff_scheduler_top
   import pbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // [31:0] now_time, [32] demand_flag, [33] poll_ok, [34] link_busy,
   // [35] cleanup_busy, [39:36] zero
   input  logic [REQ_D_W-1:0] req_tdata,
   // [2:0] opcode
   input  logic [OP_W-1:0]    req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // [0] poll_now, [1] advert_fresh, [33:2] current_backoff, [39:34] zero
   output logic [RSP_D_W-1:0] rsp_tdata,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [TIME_W-1:0]  csr_data
);

   cfg_type    cfg;
   result_type result;
   event_type  evt_ff;
   event_type  evt_in;
   logic       evt_valid_ff;
   logic       rsp_valid_ff;
   logic [RSP_D_W-1:0] rsp_data_ff;
   logic       advance;
   logic       req_take;

   assign advance    = evt_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !evt_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign evt_in.opcode       = req_tuser;
   assign evt_in.now_time     = req_tdata[TIME_W-1:0];
   assign evt_in.demand_flag  = req_tdata[TIME_W];
   assign evt_in.poll_ok      = req_tdata[TIME_W+1];
   assign evt_in.link_busy    = req_tdata[TIME_W+2];
   assign evt_in.cleanup_busy = req_tdata[TIME_W+3];

   pbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pbs_state u_state (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .evt    (evt_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            evt_valid_ff <= 1'b1;
         end else if (advance) begin
            evt_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         evt_ff <= evt_in;
      end
      if (advance) begin
         rsp_data_ff <= {{(RSP_D_W-TIME_W-2){1'b0}}, result.current_backoff,
                         result.advert_fresh, result.poll_now};
      end
   end

   `PBS_ASSERT_NEXT(a_stalled_request_held, evt_valid_ff && rsp_valid_ff && !rsp_tready, evt_valid_ff && $stable(evt_ff), "held request lost while the response was stalled")
   `PBS_ASSERT_NEXT(a_advance_gives_response, advance, rsp_valid_ff, "applied request produced no response")
   `PBS_ASSERT_SAME(a_full_blocks_request, evt_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready, "request taken while both stages were full")

endmodule

@@ test/tb_poll_backoff_scheduler_top.sv @@
// Self-checking testbench for poll_backoff_scheduler_top: directed and random traffic, with idling
// on both sides in most phases, checked request by request against an in-bench scheduler model.
// Depends on pbs_pkg and the RTL of the block.
module tb_poll_backoff_scheduler_top;
   import pbs_pkg::*;

   localparam logic [OP_W-1:0]  OP_UNUSED   = 3'd7;
   localparam logic [IDX_W-1:0] REG_UNUSED  = 3'd7;
   localparam int               CYCLE_LIMIT = 600000;

   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               req_tvalid   = 1'b0;
   logic               req_tready;
   logic [REQ_D_W-1:0] req_tdata    = '0;
   logic [OP_W-1:0]    req_tuser    = '0;
   logic               rsp_tvalid;
   logic               rsp_tready   = 1'b0;
   logic [RSP_D_W-1:0] rsp_tdata;
   logic               csr_valid    = 1'b0;
   logic               csr_ready;
   logic [IDX_W-1:0]   csr_index    = '0;
   logic [TIME_W-1:0]  csr_data     = '0;

   poll_backoff_scheduler_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Scheduler model state and its copy of the registers.
   cfg_type           sched_cfg;
   logic [TIME_W-1:0] last_finish, last_start, last_advert, retry_ready;
   logic [TIME_W-1:0] backoff_ms, wait_ms;
   logic              has_finished, has_started, has_advert;
   logic              invite, poll_req, retry_req;

   event_type  pending_events[$];
   result_type expected_results[$];
   event_type  current_event;
   int         queued_count   = 0;
   int         accepted_count = 0;
   int         error_count    = 0;
   int         send_gap       = 0;
   int         recv_gap       = 0;
   bit         idle_enabled   = 1'b1;

   // Random stream shaping, set per phase.
   logic [TIME_W-1:0] time_cursor;
   int                step_max;
   int                ok_percent;

   function automatic logic aged(input logic [TIME_W-1:0] now_ms, mark_ms, span_ms);
      return (now_ms - mark_ms) >= span_ms;
   endfunction

   function automatic logic advert_is_fresh(input logic [TIME_W-1:0] now_ms);
      return has_advert && !aged(now_ms, last_advert, sched_cfg.freshness_window);
   endfunction

   function automatic logic poll_decision(input event_type ev);
      logic [TIME_W-1:0] retry_diff;
      retry_diff = ev.now_time - retry_ready;
      if (ev.link_busy || ev.cleanup_busy || !advert_is_fresh(ev.now_time))
         return 1'b0;
      // A pending retry ignores both the start gap and the wait.
      if (retry_req)
         return !retry_diff[TIME_W-1];
      if (has_started && !aged(ev.now_time, last_start, sched_cfg.min_start_gap))
         return 1'b0;
      if (poll_req || invite || !has_finished)
         return 1'b1;
      return aged(ev.now_time, last_finish, wait_ms);
   endfunction

   function automatic result_type apply_event(input event_type ev);
      result_type        res;
      logic              silent;
      logic [TIME_W-1:0] ceiling;
      ceiling = sched_cfg.max_retry_delay;
      case (ev.opcode)
         OP_ADVERT: begin
            if (!(has_finished && !aged(ev.now_time, last_finish,
                                         sched_cfg.tail_settle_time))) begin
               silent = !has_advert ||
                        aged(ev.now_time, last_advert, sched_cfg.freshness_window);
               last_advert = ev.now_time;
               has_advert  = 1'b1;
               if (ev.demand_flag || silent)
                  invite = 1'b1;
            end
         end
         OP_START: begin
            last_start  = ev.now_time;
            has_started = 1'b1;
            poll_req    = 1'b0;
            retry_req   = 1'b0;
            invite      = 1'b0;
         end
         OP_FINISH: begin
            last_finish  = ev.now_time;
            has_finished = 1'b1;
            invite       = 1'b0;
            if (ev.poll_ok) begin
               backoff_ms = '0;
               wait_ms    = sched_cfg.normal_interval;
            end else begin
               if (backoff_ms == '0)
                  backoff_ms = (sched_cfg.first_retry_delay < ceiling) ?
                               sched_cfg.first_retry_delay : ceiling;
               else if (backoff_ms >= ceiling || backoff_ms > (ceiling >> 1))
                  backoff_ms = ceiling;
               else
                  backoff_ms = backoff_ms << 1;
               wait_ms = backoff_ms;
            end
         end
         OP_REQ_POLL: poll_req = 1'b1;
         OP_REQ_RETRY: begin
            retry_req   = 1'b1;
            retry_ready = ev.now_time + sched_cfg.retry_gap;
         end
         OP_CLEAR: begin
            poll_req  = 1'b0;
            retry_req = 1'b0;
         end
         default: ;
      endcase
      res.poll_now        = poll_decision(ev);
      res.advert_fresh    = advert_is_fresh(ev.now_time);
      res.current_backoff = backoff_ms;
      return res;
   endfunction

   task automatic add_event(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now_ms,
                            input logic demand, ok, busy, cleanup);
      event_type ev;
      ev.opcode       = op;
      ev.now_time     = now_ms;
      ev.demand_flag  = demand;
      ev.poll_ok      = ok;
      ev.link_busy    = busy;
      ev.cleanup_busy = cleanup;
      pending_events.push_back(ev);
      queued_count++;
   endtask

   // Mostly small forward steps so that the windows and gaps are actually crossed,
   // with the odd jump backwards or to anywhere in the time range.
   task automatic add_random_event();
      int                pick;
      logic [OP_W-1:0]   op;
      pick = $urandom_range(0, 99);
      if (pick < 22)      op = OP_ADVERT;
      else if (pick < 32) op = OP_START;
      else if (pick < 46) op = OP_FINISH;
      else if (pick < 56) op = OP_REQ_POLL;
      else if (pick < 66) op = OP_REQ_RETRY;
      else if (pick < 72) op = OP_CLEAR;
      else if (pick < 97) op = OP_QUERY;
      else                op = OP_UNUSED;
      if ($urandom_range(0, 31) == 0)
         time_cursor = $urandom;
      else if ($urandom_range(0, 63) == 0)
         time_cursor = time_cursor - $urandom_range(0, step_max);
      else
         time_cursor = time_cursor + $urandom_range(0, step_max);
      add_event(op, time_cursor, $urandom_range(0, 3) == 0,
                $urandom_range(0, 99) < ok_percent,
                $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
   endtask

   // Called just after a rising edge; valid stays high across back-to-back writes.
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         REG_TAIL_SETTLE: sched_cfg.tail_settle_time  = value;
         REG_FRESH_WIN:   sched_cfg.freshness_window  = value;
         REG_NORMAL_INT:  sched_cfg.normal_interval   = value;
         REG_FIRST_RETRY: sched_cfg.first_retry_delay = value;
         REG_MAX_RETRY:   sched_cfg.max_retry_delay   = value;
         REG_RETRY_GAP:   sched_cfg.retry_gap         = value;
         REG_MIN_GAP:     sched_cfg.min_start_gap     = value;
         default: ;
      endcase
   endtask

   task automatic write_config(input cfg_type c);
      write_reg(REG_TAIL_SETTLE, c.tail_settle_time);
      write_reg(REG_FRESH_WIN, c.freshness_window);
      write_reg(REG_NORMAL_INT, c.normal_interval);
      write_reg(REG_FIRST_RETRY, c.first_retry_delay);
      write_reg(REG_MAX_RETRY, c.max_retry_delay);
      write_reg(REG_RETRY_GAP, c.retry_gap);
      write_reg(REG_MIN_GAP, c.min_start_gap);
      // Writes beyond the register list must leave the settings alone.
      write_reg(REG_UNUSED, $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input cfg_type c, input int count, input int step,
                            input int ok_pct, input bit idle, input logic [TIME_W-1:0] t0);
      write_config(c);
      idle_enabled = idle;
      step_max     = step;
      ok_percent   = ok_pct;
      time_cursor  = t0;
      repeat (count) add_random_event();
      wait_idle();
   endtask

   always @(posedge clock) begin : req_driver
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_event(current_event));
            accepted_count++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 18);
            end else if (pending_events.size() > 0) begin
               current_event = pending_events.pop_front();
               next_valid    = 1'b1;
               req_tuser <= current_event.opcode;
               req_tdata <= {4'b0, current_event.cleanup_busy, current_event.link_busy,
                             current_event.poll_ok, current_event.demand_flag,
                             current_event.now_time};
            end
         end
         req_tvalid <= next_valid;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("response 0x%h arrived with no request outstanding", rsp_tdata);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[0] !== want.poll_now) begin
                  $error("poll_now: expected %0d, got %0d", want.poll_now, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[1] !== want.advert_fresh) begin
                  $error("advert_fresh: expected %0d, got %0d",
                         want.advert_fresh, rsp_tdata[1]);
                  error_count++;
               end
               if (rsp_tdata[33:2] !== want.current_backoff) begin
                  $error("current_backoff: expected %0d, got %0d",
                         want.current_backoff, rsp_tdata[33:2]);
                  error_count++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int cycle_count;
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      cfg_type cfg_base, cfg_random;
      cfg_base = '{32'd20, 32'd500, 32'd100, 32'd10, 32'd400, 32'd30, 32'd50};
      sched_cfg    = '0;
      last_finish  = '0;
      last_start   = '0;
      last_advert  = '0;
      retry_ready  = '0;
      backoff_ms   = '0;
      wait_ms      = '0;
      has_finished = 1'b0;
      has_started  = 1'b0;
      has_advert   = 1'b0;
      invite       = 1'b0;
      poll_req     = 1'b0;
      retry_req    = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk through every opcode under the base settings: first advert,
      // busy blocking, an advert in the finish tail, the backoff climbing to its
      // ceiling, a retry before and at its ready time, and the time wrap.
      write_config(cfg_base);
      add_event(OP_QUERY,     32'd0,   1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_ADVERT,    32'd5,   1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_QUERY,     32'd6,   1'b0, 1'b0, 1'b1, 1'b0);
      add_event(OP_QUERY,     32'd7,   1'b0, 1'b0, 1'b0, 1'b1);
      add_event(OP_REQ_POLL,  32'd10,  1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_START,     32'd12,  1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_FINISH,    32'd20,  1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_ADVERT,    32'd25,  1'b1, 1'b0, 1'b0, 1'b0);
      add_event(OP_ADVERT,    32'd45,  1'b1, 1'b0, 1'b0, 1'b0);
      add_event(OP_FINISH,    32'd60,  1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_FINISH,    32'd61,  1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_FINISH,    32'd62,  1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_FINISH,    32'd63,  1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_FINISH,    32'd64,  1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_FINISH,    32'd65,  1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_FINISH,    32'd66,  1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_REQ_RETRY, 32'd70,  1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_QUERY,     32'd90,  1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_QUERY,     32'd100, 1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_CLEAR,     32'd101, 1'b0, 1'b0, 1'b0, 1'b0);
      add_event(OP_UNUSED,    32'd102, 1'b1, 1'b1, 1'b1, 1'b1);
      add_event(OP_FINISH,    32'd110, 1'b0, 1'b1, 1'b0, 1'b0);
      add_event(OP_QUERY,     32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
      add_event(OP_ADVERT,    32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
      add_event(OP_START,     32'd5,   1'b0, 1'b0, 1'b0, 1'b0);
      wait_idle();

      run_phase(cfg_base, 300, 60, 50, 1'b1, 32'd1000);
      run_phase('0, 200, 4, 50, 1'b1, 32'd0);
      run_phase('1, 250, 1000, 50, 1'b1, 32'hFFFF_FF00);
      // A retry gap of half the time range sits right on the sign boundary.
      cfg_random = '{32'd5, 32'd200, 32'd50, 32'd300, 32'd500, 32'h8000_0000, 32'd0};
      run_phase(cfg_random, 250, 40, 50, 1'b1, 32'hFFFF_F000);
      // Mostly failing polls with an open ceiling let the backoff double for long.
      cfg_random = '{32'd40, 32'd300, 32'd80, 32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd25};
      run_phase(cfg_random, 300, 50, 10, 1'b1, 32'd123456);
      cfg_random = '0;
      cfg_random.tail_settle_time  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200);
      cfg_random.freshness_window  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 800);
      cfg_random.normal_interval   = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 300);
      cfg_random.first_retry_delay = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 300);
      cfg_random.max_retry_delay   = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 900);
      cfg_random.retry_gap         = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 100);
      cfg_random.min_start_gap     = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 100);
      run_phase(cfg_random, 250, 80, 40, 1'b1, $urandom);
      // Closing stretch at full rate on both sides.
      run_phase(cfg_base, 250, 60, 50, 1'b0, 32'd5000);

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
